FILE: hw/rtl/rcl_pkg.sv
// Package for the remote command line parser.
// Holds character codes, parser state encodings and shared result types.
// No dependencies.
package rcl_pkg;

    localparam int LINE_BUFFER_BYTES_DEF = 64;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_C     = 8'h43;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

    typedef enum logic [3:0] {
        PH_LIT_A  = 4'd0,
        PH_COMMA0 = 4'd1,
        PH_INT1   = 4'd2,
        PH_COMMA1 = 4'd3,
        PH_LIT_B  = 4'd4,
        PH_COMMA2 = 4'd5,
        PH_INT2   = 4'd6,
        PH_COMMA3 = 4'd7,
        PH_LIT_C  = 4'd8,
        PH_COMMA4 = 4'd9,
        PH_INT3   = 4'd10,
        PH_DONE   = 4'd11,
        PH_FAIL   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_SKIP   = 2'd0,
        ST_SIGN   = 2'd1,
        ST_DIGITS = 2'd2
    } stage_t;

    typedef struct packed {
        logic [7:0] accel;
        logic [7:0] brake;
        logic [7:0] remote;
    } values_t;

    typedef struct packed {
        logic    line_valid;
        values_t vals;
    } result_t;

    // expected literal for a literal phase, zero otherwise
    function automatic logic [7:0] lit_char(input phase_t ph);
        logic [7:0] c;
        case (ph)
            PH_LIT_A:  c = CHAR_A;
            PH_LIT_B:  c = CHAR_B;
            PH_LIT_C:  c = CHAR_C;
            PH_COMMA0: c = CHAR_COMMA;
            PH_COMMA1: c = CHAR_COMMA;
            PH_COMMA2: c = CHAR_COMMA;
            PH_COMMA3: c = CHAR_COMMA;
            PH_COMMA4: c = CHAR_COMMA;
            default:   c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/rcl_if.sv
// Handshake channels of the remote command line parser.
// Byte request channel and result channel; depends on nothing.
interface rcl_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcl_res_if;
    logic       valid;
    logic       ready;
    logic       line_valid;
    logic [7:0] accel_value;
    logic [7:0] brake_value;
    logic [7:0] remote_value;

    modport source (output valid, output line_valid, output accel_value,
                    output brake_value, output remote_value, input ready);
    modport sink   (input valid, input line_valid, input accel_value,
                    input brake_value, input remote_value, output ready);
endinterface

FILE: hw/rtl/rcl_core.sv
// Line parser state machine: one byte per enabled cycle, pattern A,%d,B,%d,C,%d.
// Depends on rcl_pkg.
module rcl_core #(
    parameter int LINE_BUFFER_BYTES = rcl_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    output rcl_pkg::result_t  result,
    output rcl_pkg::values_t  held
);

    localparam int CW = $clog2(LINE_BUFFER_BYTES);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(LINE_BUFFER_BYTES - 1);

    logic [CW-1:0]     count_reg,  count_next;
    rcl_pkg::phase_t   phase_reg,  phase_next;
    rcl_pkg::stage_t   stage_reg,  stage_next;
    logic              neg_reg,    neg_next;
    logic [31:0]       mag_reg,    mag_next;
    logic [7:0]        pend_accel_reg, pend_accel_next;
    logic [7:0]        pend_brake_reg, pend_brake_next;
    rcl_pkg::values_t  held_reg,   held_next;

    logic        is_nl, is_digit, is_space, is_sign, is_int_phase, line_ok;
    logic [3:0]  digit;
    logic [35:0] mag_step;
    logic [31:0] mag_sat;
    logic [7:0]  num_byte;

    assign is_nl    = (rx_byte == rcl_pkg::CHAR_NL);
    assign is_digit = (rx_byte >= rcl_pkg::CHAR_ZERO) && (rx_byte <= rcl_pkg::CHAR_NINE);
    assign is_space = (rx_byte == rcl_pkg::CHAR_SPACE) ||
                      ((rx_byte >= rcl_pkg::CHAR_TAB) && (rx_byte <= rcl_pkg::CHAR_CR));
    assign is_sign  = (rx_byte == rcl_pkg::CHAR_PLUS) || (rx_byte == rcl_pkg::CHAR_MINUS);
    assign digit    = rx_byte[3:0];

    assign is_int_phase = (phase_reg == rcl_pkg::PH_INT1) ||
                          (phase_reg == rcl_pkg::PH_INT2) ||
                          (phase_reg == rcl_pkg::PH_INT3);

    // mag * 10 + digit, clamped at 2^31
    assign mag_step = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {32'd0, digit};
    assign mag_sat  = (mag_step > {4'd0, rcl_pkg::MAG_LIMIT}) ? rcl_pkg::MAG_LIMIT
                                                            : mag_step[31:0];

    // magnitude never exceeds 2^31, so bit 31 marks positive saturation
    assign num_byte = neg_reg     ? 8'(8'd0 - mag_reg[7:0]) :
                      mag_reg[31] ? 8'hFF : mag_reg[7:0];

    assign line_ok = (phase_reg == rcl_pkg::PH_DONE) ||
                     ((phase_reg == rcl_pkg::PH_INT3) && (stage_reg == rcl_pkg::ST_DIGITS));

    // next state
    always_comb
    begin
        count_next      = count_reg;
        phase_next      = phase_reg;
        stage_next      = stage_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        pend_accel_next = pend_accel_reg;
        pend_brake_next = pend_brake_reg;
        held_next       = held_reg;
        if (step_en)
        begin
            if (is_nl || (count_reg >= COUNT_LIMIT))
            begin
                if (is_nl && line_ok)
                begin
                    held_next = '{accel: pend_accel_reg, brake: pend_brake_reg,
                                  remote: num_byte};
                end
                count_next = '0;
                phase_next = rcl_pkg::PH_LIT_A;
                stage_next = rcl_pkg::ST_SKIP;
                neg_next   = 1'b0;
                mag_next   = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if ((phase_reg == rcl_pkg::PH_DONE) || (phase_reg == rcl_pkg::PH_FAIL))
                begin
                    phase_next = phase_reg;
                end
                else if (rx_byte == rcl_pkg::CHAR_NUL)
                begin
                    phase_next = ((phase_reg == rcl_pkg::PH_INT3) &&
                                  (stage_reg == rcl_pkg::ST_DIGITS)) ? rcl_pkg::PH_DONE
                                                                    : rcl_pkg::PH_FAIL;
                end
                else if (!is_int_phase)
                begin
                    if (rx_byte == rcl_pkg::lit_char(phase_reg))
                    begin
                        phase_next = rcl_pkg::phase_t'(phase_reg + 4'd1);
                        stage_next = rcl_pkg::ST_SKIP;
                        neg_next   = 1'b0;
                        mag_next   = '0;
                    end
                    else
                    begin
                        phase_next = rcl_pkg::PH_FAIL;
                    end
                end
                else
                begin
                    case (stage_reg)
                        rcl_pkg::ST_SKIP:
                        begin
                            if (is_sign)
                            begin
                                neg_next   = (rx_byte == rcl_pkg::CHAR_MINUS);
                                stage_next = rcl_pkg::ST_SIGN;
                            end
                            else if (is_digit)
                            begin
                                mag_next   = {28'd0, digit};
                                stage_next = rcl_pkg::ST_DIGITS;
                            end
                            else if (!is_space)
                            begin
                                phase_next = rcl_pkg::PH_FAIL;
                            end
                        end
                        rcl_pkg::ST_SIGN:
                        begin
                            if (is_digit)
                            begin
                                mag_next   = {28'd0, digit};
                                stage_next = rcl_pkg::ST_DIGITS;
                            end
                            else
                            begin
                                phase_next = rcl_pkg::PH_FAIL;
                            end
                        end
                        rcl_pkg::ST_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                mag_next = mag_sat;
                            end
                            else if (phase_reg == rcl_pkg::PH_INT3)
                            begin
                                phase_next = rcl_pkg::PH_DONE;
                            end
                            else
                            begin
                                if (phase_reg == rcl_pkg::PH_INT1)
                                begin
                                    pend_accel_next = num_byte;
                                end
                                else
                                begin
                                    pend_brake_next = num_byte;
                                end
                                // number ends; the byte must be the following comma
                                if (rx_byte == rcl_pkg::CHAR_COMMA)
                                begin
                                    phase_next = rcl_pkg::phase_t'(phase_reg + 4'd2);
                                    stage_next = rcl_pkg::ST_SKIP;
                                    neg_next   = 1'b0;
                                    mag_next   = '0;
                                end
                                else
                                begin
                                    phase_next = rcl_pkg::PH_FAIL;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = rcl_pkg::PH_FAIL;
                        end
                    endcase
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        result.line_valid = line_ok;
        if (line_ok)
        begin
            result.vals = '{accel: pend_accel_reg, brake: pend_brake_reg, remote: num_byte};
        end
        else
        begin
            result.vals = held_reg;
        end
        held = held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            phase_reg      <= rcl_pkg::PH_LIT_A;
            stage_reg      <= rcl_pkg::ST_SKIP;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            pend_accel_reg <= '0;
            pend_brake_reg <= '0;
            held_reg       <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            stage_reg      <= stage_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            pend_accel_reg <= pend_accel_next;
            pend_brake_reg <= pend_brake_next;
            held_reg       <= held_next;
        end
    end

endmodule

FILE: hw/rtl/remote_command_line_parser.sv
// A byte request is held in the input register and parsed when the core steps on it;
// a newline's result is registered at the output in that step and then offered.
// One byte per cycle unless stalled; input register, parser step, output register.
// A newline stalls in the input register only while an earlier result is not taken.
// Reset (rst_n, async, active low) clears the line, the parser and held values to zero.
// Top level of the remote command line parser; depends on rcl_pkg, rcl_if, rcl_core.
module remote_command_line_parser #(
    parameter int LINE_BUFFER_BYTES = rcl_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rcl_rx_if.sink    rx_ch,
    rcl_res_if.source result_ch
);

    logic              s1_valid_reg, s1_valid_next;
    logic [7:0]        s1_byte_reg,  s1_byte_next;
    logic              out_valid_reg, out_valid_next;
    rcl_pkg::result_t  out_data_reg,  out_data_next;

    logic              s1_is_nl, advance, step_en, rx_fire;
    rcl_pkg::result_t  core_result;
    rcl_pkg::values_t  core_held;

    assign s1_is_nl = (s1_byte_reg == rcl_pkg::CHAR_NL);
    assign advance  = !s1_valid_reg || !s1_is_nl || !out_valid_reg || result_ch.ready;
    assign step_en  = s1_valid_reg && advance;
    assign rx_fire  = rx_ch.valid && advance;

    assign rx_ch.ready = advance;

    rcl_core #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (s1_byte_reg),
        .result  (core_result),
        .held    (core_held)
    );

    always_comb
    begin
        s1_valid_next = rx_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        s1_byte_next  = rx_fire ? rx_ch.rx_byte : s1_byte_reg;
        if (step_en && s1_is_nl)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_result;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result_ch.ready;
            out_data_next  = out_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_byte_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_byte_reg   <= s1_byte_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.line_valid   = out_data_reg.line_valid;
    assign result_ch.accel_value  = out_data_reg.vals.accel;
    assign result_ch.brake_value  = out_data_reg.vals.brake;
    assign result_ch.remote_value = out_data_reg.vals.remote;

    // a newline is never parsed while a pending result would be overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        !(step_en && s1_is_nl && out_valid_reg && !result_ch.ready))
        else $error("result register overwritten");

    // a failed line reports exactly the values held in the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.line_valid) |-> (out_data_reg.vals == core_held))
        else $error("failed line does not report held values");

    // byte requests are refused only behind a stalled newline
    assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ch.ready |-> (s1_valid_reg && s1_is_nl && out_valid_reg))
        else $error("byte request refused without stall");

endmodule
